// ===== src/logic_formula_syntax_checker_unit_macros.svh =====
// Assertion helpers shared by the checker RTL.
`ifndef LOGIC_FORMULA_SYNTAX_CHECKER_UNIT_MACROS_SVH
`define LOGIC_FORMULA_SYNTAX_CHECKER_UNIT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define LFSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define LFSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/lfsc_pkg.sv =====
package lfsc_pkg;

	localparam int SymbolW = 8;

	// Characters of the formula alphabet
	localparam logic [SymbolW-1:0] CH_LPAREN = 8'h28;
	localparam logic [SymbolW-1:0] CH_RPAREN = 8'h29;
	localparam logic [SymbolW-1:0] CH_BANG   = 8'h21;
	localparam logic [SymbolW-1:0] CH_SLASH  = 8'h2f;
	localparam logic [SymbolW-1:0] CH_BSLASH = 8'h5c;
	localparam logic [SymbolW-1:0] CH_MINUS  = 8'h2d;
	localparam logic [SymbolW-1:0] CH_GT     = 8'h3e;
	localparam logic [SymbolW-1:0] CH_TILDE  = 8'h7e;
	localparam logic [SymbolW-1:0] CH_ZERO   = 8'h30;
	localparam logic [SymbolW-1:0] CH_ONE    = 8'h31;
	localparam logic [SymbolW-1:0] CH_A      = 8'h41;
	localparam logic [SymbolW-1:0] CH_Z      = 8'h5a;

	// Verdict codes
	localparam logic [1:0] VERDICT_READING = 2'd0;
	localparam logic [1:0] VERDICT_CORRECT = 2'd1;
	localparam logic [1:0] VERDICT_ERROR   = 2'd2;

	// Kind of an open parenthesis
	typedef enum logic [1:0] {
		KIND_UNARY      = 2'd0,
		KIND_BIN_FIRST  = 2'd1,
		KIND_BIN_SECOND = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		MODE_EXPECT_F  = 3'd0,
		MODE_AFTER_LP  = 3'd1,
		MODE_EXPECT_OP = 3'd2,
		MODE_OP_SECOND = 3'd3,
		MODE_EXPECT_RP = 3'd4,
		MODE_DONE      = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		STK_HOLD,
		STK_PUSH,
		STK_POP,
		STK_SET,
		STK_CLEAR
	} stk_cmd_t;

	// Request from the parser to the frame stack
	typedef struct packed {
		stk_cmd_t cmd;
		kind_t    kind;
	} stk_op_t;

	// Frame stack status seen by the parser
	typedef struct packed {
		logic  empty;
		logic  one;
		logic  full;
		kind_t top;
		kind_t below;
	} stk_stat_t;

	// Parser registers other than the stack
	typedef struct packed {
		mode_t              mode;
		logic [SymbolW-1:0] held;
		logic               err;
	} parse_state_t;

endpackage

// ===== src/lfsc_stack.sv =====
`include "logic_formula_syntax_checker_unit_macros.svh"

module lfsc_stack
	import lfsc_pkg::*;
#(
	parameter int MAX_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  stk_op_t   op,
	output stk_stat_t stat
);

	localparam int DW       = $clog2(MAX_DEPTH + 1);
	localparam int AW       = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int MemDepth = 1 << AW;

	// Top frame lives in a register, frames beneath it in the memory.
	logic [DW-1:0] depth_q;
	kind_t         top_q;
	kind_t         below_q;
	kind_t         mem [MemDepth];

	logic [DW-1:0] depth_nxt;
	logic [DW-1:0] wa_full;
	logic [DW-1:0] ra_full;
	logic [AW-1:0] wa;
	logic [AW-1:0] ra;
	logic          we;
	logic          upd;

	assign upd = en && (op.cmd != STK_HOLD);

	always_comb begin
		depth_nxt = depth_q;
		if (en) begin
			case (op.cmd)
				STK_PUSH:  depth_nxt = depth_q + DW'(1);
				STK_POP:   depth_nxt = depth_q - DW'(1);
				STK_CLEAR: depth_nxt = '0;
				default:   depth_nxt = depth_q;
			endcase
		end
	end

	// Old top spills to the slot just below the new top on a push
	assign we      = en && (op.cmd == STK_PUSH) && (depth_q != '0);
	assign wa_full = depth_q - DW'(1);
	assign wa      = wa_full[AW-1:0];
	// Prefetch the frame that will sit under the top after this cycle
	assign ra_full = depth_nxt - DW'(2);
	assign ra      = ra_full[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= top_q;
		end
		if (we && (wa == ra)) begin
			below_q <= top_q;
		end else begin
			below_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			top_q   <= KIND_UNARY;
		end else if (upd) begin
			depth_q <= depth_nxt;
			case (op.cmd)
				STK_PUSH: top_q <= op.kind;
				STK_POP:  top_q <= below_q;
				STK_SET:  top_q <= op.kind;
				default:  top_q <= top_q;
			endcase
		end
	end

	assign stat.empty = (depth_q == '0);
	assign stat.one   = (depth_q == DW'(1));
	assign stat.full  = (depth_q >= DW'(MAX_DEPTH));
	assign stat.top   = top_q;
	assign stat.below = below_q;

	`LFSC_ASSERT_ALWAYS(a_depth_bound, clk, !arst_n || (depth_q <= DW'(MAX_DEPTH)), "stack depth over bound")
	`LFSC_ASSERT(a_no_pop_empty, clk, arst_n, (en && op.cmd == STK_POP) |-> !stat.empty, "pop on empty stack")
	`LFSC_ASSERT(a_no_push_full, clk, arst_n, (en && op.cmd == STK_PUSH) |-> !stat.full, "push on full stack")

endmodule

// ===== src/lfsc_parser.sv =====
module lfsc_parser
	import lfsc_pkg::*;
(
	input  logic [SymbolW-1:0] symbol,
	input  logic               end_of_text,
	input  parse_state_t       cur,
	input  stk_stat_t          stat,
	output parse_state_t       nxt,
	output stk_op_t            op,
	output logic [1:0]         verdict
);

	// Mode after a subformula closes, given the frame now on top
	function automatic mode_t done_mode(input logic empty, input kind_t top);
		mode_t m;
		if (empty) begin
			m = MODE_DONE;
		end else if (top == KIND_BIN_FIRST) begin
			m = MODE_EXPECT_OP;
		end else begin
			m = MODE_EXPECT_RP;
		end
		return m;
	endfunction

	logic               atom;
	logic [SymbolW-1:0] need;

	assign atom = symbol inside {CH_ZERO, CH_ONE, [CH_A:CH_Z]};

	// Second character that completes a two-character operator
	always_comb begin
		case (cur.held)
			CH_SLASH:  need = CH_BSLASH;
			CH_BSLASH: need = CH_SLASH;
			default:   need = CH_GT;
		endcase
	end

	always_comb begin
		nxt      = cur;
		op.cmd   = STK_HOLD;
		op.kind  = KIND_UNARY;
		verdict  = VERDICT_READING;
		if (end_of_text) begin
			// Final verdict, then rearm
			verdict  = (!cur.err && cur.mode == MODE_DONE) ? VERDICT_CORRECT : VERDICT_ERROR;
			nxt.mode = MODE_EXPECT_F;
			nxt.held = '0;
			nxt.err  = 1'b0;
			op.cmd   = STK_CLEAR;
		end else if (cur.err) begin
			verdict = VERDICT_ERROR;
		end else begin
			nxt.held = symbol;
			case (cur.mode)
				MODE_EXPECT_F, MODE_AFTER_LP: begin
					if (cur.mode == MODE_AFTER_LP && symbol == CH_BANG) begin
						if (stat.empty) begin
							nxt.err = 1'b1;
						end else begin
							op.cmd   = STK_SET;
							op.kind  = KIND_UNARY;
							nxt.mode = MODE_EXPECT_F;
						end
					end else if (atom) begin
						nxt.mode = done_mode(stat.empty, stat.top);
					end else if (symbol == CH_LPAREN) begin
						if (stat.full) begin
							nxt.err = 1'b1;
						end else begin
							op.cmd   = STK_PUSH;
							op.kind  = KIND_BIN_FIRST;
							nxt.mode = MODE_AFTER_LP;
						end
					end else begin
						nxt.err = 1'b1;
					end
				end
				MODE_EXPECT_OP: begin
					if (stat.empty) begin
						nxt.err = 1'b1;
					end else if (symbol == CH_SLASH || symbol == CH_BSLASH
							|| symbol == CH_MINUS) begin
						nxt.mode = MODE_OP_SECOND;
					end else if (symbol == CH_TILDE) begin
						op.cmd   = STK_SET;
						op.kind  = KIND_BIN_SECOND;
						nxt.mode = MODE_EXPECT_F;
					end else begin
						nxt.err = 1'b1;
					end
				end
				MODE_OP_SECOND: begin
					if (stat.empty || symbol != need) begin
						nxt.err = 1'b1;
					end else begin
						op.cmd   = STK_SET;
						op.kind  = KIND_BIN_SECOND;
						nxt.mode = MODE_EXPECT_F;
					end
				end
				MODE_EXPECT_RP: begin
					if (stat.empty || symbol != CH_RPAREN) begin
						nxt.err = 1'b1;
					end else begin
						op.cmd   = STK_POP;
						nxt.mode = done_mode(stat.one, stat.below);
					end
				end
				default: begin
					// Text after a complete formula
					nxt.err = 1'b1;
				end
			endcase
			verdict = nxt.err ? VERDICT_ERROR : VERDICT_READING;
		end
	end

endmodule

// ===== src/logic_formula_syntax_checker_unit.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_ready    symbol[7:0], end_of_text
// output    out_valid / out_ready  verdict[1:0]
//
// One item per cycle sustained while out_ready holds; each item's verdict is
// registered after acceptance: input register, then parse step into the result register.
// The parse step touches only the stack top register, a prefetched copy of the
// frame below it and the mode registers, so consecutive items never wait on the stack.
// Reset (arst_n low) empties the stack and arms the parser for a new formula;
// there is no clearing pass. A stalled result holds the parse state; the input
// register still takes one more item.
`include "logic_formula_syntax_checker_unit_macros.svh"

module logic_formula_syntax_checker_unit
	import lfsc_pkg::*;
#(
	parameter int MAX_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [SymbolW-1:0] symbol,
	input  logic               end_of_text,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         verdict
);

	logic               valid_s1;
	logic [SymbolW-1:0] symbol_s1;
	logic               eot_s1;
	logic               valid_s2;
	logic [1:0]         verdict_s2;

	parse_state_t cur_q;
	parse_state_t nxt;
	stk_op_t      op;
	stk_stat_t    stat;
	logic [1:0]   verdict_nxt;
	logic         advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			symbol_s1 <= symbol;
			eot_s1    <= end_of_text;
		end
	end

	lfsc_parser u_parser (
		.symbol      (symbol_s1),
		.end_of_text (eot_s1),
		.cur         (cur_q),
		.stat        (stat),
		.nxt         (nxt),
		.op          (op),
		.verdict     (verdict_nxt)
	);

	lfsc_stack #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.op     (op),
		.stat   (stat)
	);

	// Parser state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.mode <= MODE_EXPECT_F;
			cur_q.held <= '0;
			cur_q.err  <= 1'b0;
		end else if (advance) begin
			cur_q <= nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_s2 <= verdict_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign verdict   = verdict_s2;

	`LFSC_ASSERT(a_correct_only_at_end, clk, arst_n, (advance && !eot_s1) |=> verdict != VERDICT_CORRECT, "correct verdict on a non-end item")
	`LFSC_ASSERT(a_rearm_after_end, clk, arst_n, (advance && eot_s1) |=> (cur_q.mode == MODE_EXPECT_F && !cur_q.err), "parser not rearmed after end")
	`LFSC_ASSERT(a_error_sticky, clk, arst_n, (advance && !eot_s1 && cur_q.err) |=> (cur_q.err && verdict == VERDICT_ERROR), "error flag dropped before end")
	`LFSC_ASSERT(a_state_held_on_stall, clk, arst_n, !advance |=> $stable(cur_q), "parser state moved without an item")

endmodule
